FILE: sv/kwm_pkg.sv
`default_nettype none

package kwm_pkg;

   // Outcome of one transaction as decided by the lane state logic.
   typedef struct packed {
      logic bad;    // lane inactive, already full or already finished
      logic hold;   // some active lane still waits for input, no result
      logic done;   // every active lane finished, merge restarts
      logic emit;   // smallest head leaves
   } step_flags_type;

endpackage

`default_nettype wire

FILE: sv/k_way_merge_selector.sv
// A transaction is accepted into the input register, then makes one pass through the lane
// update and min tree into the result register. One transaction is taken per cycle unless
// results stall; the min tree over all lanes sets the cycle time.
// A transaction that leaves some active lane waiting produces no result.
// Reset (synchronous, active high) clears all lane flags and sets active_lanes to LANES;
// head values are not cleared and need no clearing pass.
`default_nettype none

module k_way_merge_selector #(
   parameter int LANES      = 8,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [$clog2(LANES+1)-1:0]         csr_wdata,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [$clog2(LANES)-1:0]           req_lane,
   input  wire logic signed [VALUE_BITS-1:0]       req_value,
   input  wire logic                               req_lane_end,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [VALUE_BITS-1:0]            rsp_value_res,
   output logic [$clog2(LANES)-1:0]                rsp_lane_res,
   output logic                                    rsp_all_done,
   output logic                                    rsp_bad_item
);

   localparam int LANE_BITS = $clog2(LANES);
   localparam int CNT_BITS  = $clog2(LANES + 1);

   logic [CNT_BITS-1:0]          active_lanes_ff;
   logic                         in_valid_ff;
   logic [LANE_BITS-1:0]         in_lane_ff;
   logic signed [VALUE_BITS-1:0] in_value_ff;
   logic                         in_end_ff;
   logic                         rsp_valid_ff;
   logic signed [VALUE_BITS-1:0] rsp_value_ff;
   logic [LANE_BITS-1:0]         rsp_lane_ff;
   logic                         rsp_done_ff;
   logic                         rsp_bad_ff;

   logic                         fire;
   kwm_pkg::step_flags_type      flags;
   logic signed [VALUE_BITS-1:0] best_value;
   logic [LANE_BITS-1:0]         best_lane;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_lanes_ff <= CNT_BITS'(LANES);
      end else if (csr_we) begin
         active_lanes_ff <= csr_wdata;
      end
   end

   // The registered transaction is processed once the result register can take its outcome.
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_lane_ff  <= req_lane;
         in_value_ff <= req_value;
         in_end_ff   <= req_lane_end;
      end
   end

   kwm_lanes #(
      .LANES      (LANES),
      .VALUE_BITS (VALUE_BITS),
      .LANE_BITS  (LANE_BITS),
      .CNT_BITS   (CNT_BITS)
   ) u_lanes (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .active_count (active_lanes_ff),
      .item_lane    (in_lane_ff),
      .item_value   (in_value_ff),
      .item_end     (in_end_ff),
      .flags        (flags),
      .best_value   (best_value),
      .best_lane    (best_lane)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= !flags.hold;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_value_ff <= flags.emit ? best_value : '0;
         rsp_lane_ff  <= flags.bad ? in_lane_ff : (flags.emit ? best_lane : '0);
         rsp_done_ff  <= flags.done;
         rsp_bad_ff   <= flags.bad;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_lane_res  = rsp_lane_ff;
   assign rsp_all_done  = rsp_done_ff;
   assign rsp_bad_item  = rsp_bad_ff;

`ifndef SYNTHESIS
   a_hold_no_result: assert property (@(posedge clock) disable iff (reset)
      fire && flags.hold |=> !rsp_valid_ff)
      else $error("waiting transaction produced a result");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_done_ff && rsp_bad_ff))
      else $error("result marked both done and bad");

   a_input_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_lane_ff))
      else $error("stalled transaction lost from input register");
`endif

endmodule

`default_nettype wire

FILE: sv/kwm_min_tree.sv
`default_nettype none

module kwm_min_tree #(
   parameter int LANES      = 8,
   parameter int VALUE_BITS = 32,
   parameter int LANE_BITS  = 3
) (
   input  wire logic [LANES-1:0]             leaf_valid,
   input  wire logic signed [VALUE_BITS-1:0] leaf_value [LANES],
   output logic                              best_valid,
   output logic signed [VALUE_BITS-1:0]      best_value,
   output logic [LANE_BITS-1:0]              best_lane
);

   localparam int LEAVES = 1 << LANE_BITS;
   localparam int NODES  = 2 * LEAVES - 1;

   logic                         node_valid [NODES];
   logic signed [VALUE_BITS-1:0] node_value [NODES];
   logic [LANE_BITS-1:0]         node_lane  [NODES];

   // Leaves sit at the bottom of a heap-ordered array; padding leaves are empty.
   for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
      if (g < LANES) begin : g_real
         assign node_valid[LEAVES-1+g] = leaf_valid[g];
         assign node_value[LEAVES-1+g] = leaf_value[g];
      end else begin : g_pad
         assign node_valid[LEAVES-1+g] = 1'b0;
         assign node_value[LEAVES-1+g] = '0;
      end
      assign node_lane[LEAVES-1+g] = LANE_BITS'(g);
   end

   // Each node keeps the smaller child; the left child holds lower lanes, so it wins ties.
   for (genvar i = 0; i < LEAVES - 1; i++) begin : g_node
      logic take_left;
      assign take_left = node_valid[2*i+1] &&
                         (!node_valid[2*i+2] || (node_value[2*i+1] <= node_value[2*i+2]));
      assign node_valid[i] = node_valid[2*i+1] || node_valid[2*i+2];
      assign node_value[i] = take_left ? node_value[2*i+1] : node_value[2*i+2];
      assign node_lane[i]  = take_left ? node_lane[2*i+1]  : node_lane[2*i+2];
   end

   assign best_valid = node_valid[0];
   assign best_value = node_value[0];
   assign best_lane  = node_lane[0];

endmodule

`default_nettype wire

FILE: sv/kwm_lanes.sv
`default_nettype none

module kwm_lanes #(
   parameter int LANES      = 8,
   parameter int VALUE_BITS = 32,
   parameter int LANE_BITS  = 3,
   parameter int CNT_BITS   = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         fire,
   input  wire logic [CNT_BITS-1:0]          active_count,
   input  wire logic [LANE_BITS-1:0]         item_lane,
   input  wire logic signed [VALUE_BITS-1:0] item_value,
   input  wire logic                         item_end,
   output kwm_pkg::step_flags_type           flags,
   output logic signed [VALUE_BITS-1:0]      best_value,
   output logic [LANE_BITS-1:0]              best_lane
);

   logic signed [VALUE_BITS-1:0] head_value_ff [LANES];
   logic [LANES-1:0]             head_present_ff;
   logic [LANES-1:0]             lane_finished_ff;
   logic [LANES-1:0]             head_present_in;
   logic [LANES-1:0]             lane_finished_in;

   logic [CNT_BITS-1:0]          lanes_eff;
   logic [LANES-1:0]             lane_active;
   logic [LANES-1:0]             lane_sel;
   logic [LANES-1:0]             best_sel;
   logic [LANES-1:0]             present_upd;
   logic [LANES-1:0]             finished_upd;
   logic signed [VALUE_BITS-1:0] cand_value [LANES];
   logic                         best_valid;
   logic                         bad_lane;
   logic                         all_ready;

   // Register values outside 1..LANES are clamped.
   always_comb begin
      if (active_count == '0) begin
         lanes_eff = CNT_BITS'(1);
      end else if (active_count > CNT_BITS'(LANES)) begin
         lanes_eff = CNT_BITS'(LANES);
      end else begin
         lanes_eff = active_count;
      end
   end

   // Per-lane decode, state as it stands after this transaction's own update.
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      assign lane_active[k] = CNT_BITS'(k) < lanes_eff;
      assign lane_sel[k]    = item_lane == LANE_BITS'(k);
      assign best_sel[k]    = best_lane == LANE_BITS'(k);
      assign cand_value[k]  = lane_sel[k] ? item_value : head_value_ff[k];
   end

   assign present_upd  = head_present_ff | (lane_sel & {LANES{!item_end}});
   assign finished_upd = lane_finished_ff | (lane_sel & {LANES{item_end}});

   assign bad_lane  = (CNT_BITS'(item_lane) >= lanes_eff) ||
                      ((lane_sel & (head_present_ff | lane_finished_ff)) != '0);
   assign all_ready = &(present_upd | finished_upd | ~lane_active);

   kwm_min_tree #(
      .LANES      (LANES),
      .VALUE_BITS (VALUE_BITS),
      .LANE_BITS  (LANE_BITS)
   ) u_tree (
      .leaf_valid (present_upd & lane_active),
      .leaf_value (cand_value),
      .best_valid (best_valid),
      .best_value (best_value),
      .best_lane  (best_lane)
   );

   // Classify the transaction.
   always_comb begin
      flags.bad  = bad_lane;
      flags.hold = !bad_lane && !all_ready;
      flags.done = !bad_lane && all_ready && !best_valid;
      flags.emit = !bad_lane && all_ready && best_valid;
   end

   // Next lane flags.
   always_comb begin
      head_present_in  = head_present_ff;
      lane_finished_in = lane_finished_ff;
      if (fire) begin
         if (flags.done) begin
            head_present_in  = '0;
            lane_finished_in = '0;
         end else if (!flags.bad) begin
            head_present_in  = flags.emit ? (present_upd & ~best_sel) : present_upd;
            lane_finished_in = finished_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_present_ff  <= '0;
         lane_finished_ff <= '0;
      end else begin
         head_present_ff  <= head_present_in;
         lane_finished_ff <= lane_finished_in;
      end
   end

   // Head storage is written only by a good value transaction.
   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         if (fire && !bad_lane && !item_end && lane_sel[k]) begin
            head_value_ff[k] <= item_value;
         end
      end
   end

`ifndef SYNTHESIS
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      fire && flags.done |=> head_present_ff == '0 && lane_finished_ff == '0)
      else $error("lane flags not cleared after merge end");

   a_emit_frees_lane: assert property (@(posedge clock) disable iff (reset)
      fire && flags.emit |=> (head_present_ff & $past(best_sel)) == '0)
      else $error("emitted lane still holds a head");

   a_bad_keeps_state: assert property (@(posedge clock) disable iff (reset)
      fire && flags.bad |=> $stable(head_present_ff) && $stable(lane_finished_ff))
      else $error("rejected transaction changed lane flags");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_k_way_merge_selector.sv
`timescale 1ns / 1ps

module tb_k_way_merge_selector;

   localparam int LANES         = 8;
   localparam int VALUE_BITS    = 32;
   localparam int LANE_BITS     = $clog2(LANES);
   localparam int CSR_BITS      = $clog2(LANES + 1);
   localparam int RANDOM_ITEMS  = 525;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 400000;

   // One result transaction as the block should present it.
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [LANE_BITS-1:0]         lane;
      logic                         all_done;
      logic                         bad_item;
   } merge_result_type;

   typedef enum logic {ROW_ITEM, ROW_LANES} row_kind_type;

   // One row of the directed script. A ROW_LANES row carries the new lane count in value.
   typedef struct packed {
      row_kind_type                 kind;
      logic [LANE_BITS-1:0]         lane;
      logic signed [VALUE_BITS-1:0] value;
      logic                         lane_end;
      logic                         typed;
      merge_result_type             want;
   } script_row_type;

   localparam merge_result_type NO_CHECK = '0;
   localparam logic signed [VALUE_BITS-1:0] VAL_MIN = 32'sh80000000;
   localparam logic signed [VALUE_BITS-1:0] VAL_MAX = 32'sh7FFFFFFF;
   localparam int SCRIPT_ROWS = 28;

   // Directed script: an eight-lane merge whose lane count changes in the middle, rejected
   // transactions, extreme values with a tie, and a lane count of zero.
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{ROW_ITEM,  3'd1, 32'sd7,       1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd2, -32'sd7,      1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd3, 32'sd0,       1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd4, 32'sd1,       1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd5, 32'sd100,     1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd6, -32'sd1,      1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd7, 32'sd7,       1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd0, -32'sd1000,   1'b0, 1'b0, NO_CHECK},
      '{ROW_LANES, 3'd0, 32'sd2,       1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd0, 32'sd0,       1'b1, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd1, 32'sd0,       1'b1, 1'b1, '{32'sd0, 3'd0, 1'b1, 1'b0}},
      '{ROW_LANES, 3'd0, 32'sd3,       1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd3, 32'sd0,       1'b0, 1'b1, '{32'sd0, 3'd3, 1'b0, 1'b1}},
      '{ROW_ITEM,  3'd7, -32'sd1,      1'b1, 1'b1, '{32'sd0, 3'd7, 1'b0, 1'b1}},
      '{ROW_ITEM,  3'd0, VAL_MAX,      1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd0, 32'sd5,       1'b0, 1'b1, '{32'sd0, 3'd0, 1'b0, 1'b1}},
      '{ROW_ITEM,  3'd1, VAL_MIN,      1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd2, VAL_MIN,      1'b0, 1'b1, '{VAL_MIN, 3'd1, 1'b0, 1'b0}},
      '{ROW_ITEM,  3'd1, 32'sd0,       1'b1, 1'b1, '{VAL_MIN, 3'd2, 1'b0, 1'b0}},
      '{ROW_ITEM,  3'd1, 32'sd3,       1'b0, 1'b1, '{32'sd0, 3'd1, 1'b0, 1'b1}},
      '{ROW_ITEM,  3'd2, -32'sd1,      1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd2, -32'sd1,      1'b1, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd0, 32'sd0,       1'b1, 1'b1, '{32'sd0, 3'd0, 1'b1, 1'b0}},
      '{ROW_LANES, 3'd0, 32'sd0,       1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd1, 32'sd0,       1'b0, 1'b1, '{32'sd0, 3'd1, 1'b0, 1'b1}},
      '{ROW_ITEM,  3'd0, 32'sh55555555, 1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd0, 32'shAAAAAAAA, 1'b0, 1'b0, NO_CHECK},
      '{ROW_ITEM,  3'd0, 32'sd0,       1'b1, 1'b1, '{32'sd0, 3'd0, 1'b1, 1'b0}}
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_we = 1'b0;
   logic [CSR_BITS-1:0]          csr_wdata = '0;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [LANE_BITS-1:0]         req_lane = '0;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic                         req_lane_end = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [VALUE_BITS-1:0] rsp_value_res;
   logic [LANE_BITS-1:0]         rsp_lane_res;
   logic                         rsp_all_done;
   logic                         rsp_bad_item;

   // Predicted merge state and the lane count register as the block should hold them.
   logic signed [VALUE_BITS-1:0] head_val [LANES];
   bit                           head_full [LANES];
   bit                           lane_done [LANES];
   logic [CSR_BITS-1:0]          lanes_cfg = 4'd8;

   // Source side of each lane during the random part: items left and last value sent.
   int                           lane_budget [LANES];
   logic signed [VALUE_BITS-1:0] lane_last [LANES];

   merge_result_type pending_results [$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   bit               steady = 1'b0;
   bit               restarted = 1'b0;

   k_way_merge_selector #(
      .LANES      (LANES),
      .VALUE_BITS (VALUE_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_lane      (req_lane),
      .req_value     (req_value),
      .req_lane_end  (req_lane_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_lane_res  (rsp_lane_res),
      .rsp_all_done  (rsp_all_done),
      .rsp_bad_item  (rsp_bad_item)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Number of lanes taking part, with out-of-range register values folded in.
   function automatic int live_lanes();
      if (lanes_cfg == 0) return 1;
      if (lanes_cfg > LANES) return LANES;
      return lanes_cfg;
   endfunction

   // Applies one request to the predicted state and returns whether a result follows.
   function automatic bit merge_predict(input logic [LANE_BITS-1:0] lane,
                                        input logic signed [VALUE_BITS-1:0] value,
                                        input logic lane_end,
                                        output merge_result_type res);
      int n;
      int best;
      bit waiting;
      n = live_lanes();
      best = -1;
      waiting = 1'b0;
      res = '0;
      // Inactive, full or finished lanes reject the transaction and keep the state.
      if (lane >= n || head_full[lane] || lane_done[lane]) begin
         res.lane = lane;
         res.bad_item = 1'b1;
         return 1'b1;
      end
      if (lane_end) begin
         lane_done[lane] = 1'b1;
      end else begin
         head_val[lane] = value;
         head_full[lane] = 1'b1;
      end
      // Smallest head over the active lanes; strict compare keeps the lowest lane on ties.
      for (int k = 0; k < n; k++) begin
         if (head_full[k]) begin
            if (best < 0 || head_val[k] < head_val[best]) best = k;
         end else if (!lane_done[k]) begin
            waiting = 1'b1;
         end
      end
      if (waiting) return 1'b0;
      // Every active lane finished: the merge ends and all lanes are cleared.
      if (best < 0) begin
         for (int k = 0; k < LANES; k++) begin
            head_full[k] = 1'b0;
            lane_done[k] = 1'b0;
         end
         res.all_done = 1'b1;
         return 1'b1;
      end
      head_full[best] = 1'b0;
      res.value = head_val[best];
      res.lane = LANE_BITS'(best);
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: ERROR: %s", $time, msg);
      mismatch_count++;
   endtask

   // Presents one request transaction, waits for its acceptance and records the outcome.
   task automatic send_item(input logic [LANE_BITS-1:0] lane,
                            input logic signed [VALUE_BITS-1:0] value,
                            input logic lane_end,
                            input logic typed,
                            input merge_result_type want);
      merge_result_type predicted;
      bit has_res;
      int gap;
      // Outside the steady stretch, a one-cycle pause comes before about a quarter of the
      // items and keeps the sender idle at those times.
      gap = (!steady && $urandom_range(99) < 23) ? 1 : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_lane <= lane;
      req_value <= value;
      req_lane_end <= lane_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      has_res = merge_predict(lane, value, lane_end, predicted);
      if (typed) begin
         pending_results.push_back(want);
      end else if (has_res) begin
         pending_results.push_back(predicted);
      end
      restarted = has_res && predicted.all_done;
   endtask

   // Holds the sender until every result has come and the pipeline has emptied.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic reconfigure(input logic [CSR_BITS-1:0] count);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      lanes_cfg = count;
      csr_we <= 1'b0;
   endtask

   // Gives every lane a fresh length and starting point for the next merge.
   task automatic plan_merge();
      for (int l = 0; l < LANES; l++) begin
         lane_budget[l] = ($urandom_range(9) == 0) ? $urandom_range(5, 12)
                                                    : $urandom_range(0, 3);
         case ($urandom_range(3))
            0: lane_last[l] = VAL_MIN;
            1: lane_last[l] = $urandom;
            default: lane_last[l] = $signed(32'($urandom_range(2000))) - 32'sd1000;
         endcase
      end
   endtask

   // Receiver stalls at random, except during the steady stretch.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 19);
   end

   // Compares each accepted result transaction with the oldest prediction.
   always @(posedge clock) begin : check_results
      merge_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d lane %0d done %b bad %b",
                                      rsp_value_res, rsp_lane_res, rsp_all_done,
                                      rsp_bad_item));
         end else begin
            want = pending_results.pop_front();
            if (rsp_value_res !== want.value)
               report_mismatch($sformatf("value_res %0d, expected %0d",
                                         rsp_value_res, want.value));
            if (rsp_lane_res !== want.lane)
               report_mismatch($sformatf("lane_res %0d, expected %0d",
                                         rsp_lane_res, want.lane));
            if (rsp_all_done !== want.all_done)
               report_mismatch($sformatf("all_done %b, expected %b",
                                         rsp_all_done, want.all_done));
            if (rsp_bad_item !== want.bad_item)
               report_mismatch($sformatf("bad_item %b, expected %b",
                                         rsp_bad_item, want.bad_item));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** k_way_merge_selector: FAILED **");
         $finish;
      end
   end

   initial begin
      int open_lanes [$];
      int pick;
      int l;
      longint next_val;
      logic [LANE_BITS-1:0] lane;
      logic signed [VALUE_BITS-1:0] value;
      logic lane_end;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed script.
      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         if (SCRIPT[r].kind == ROW_LANES) begin
            reconfigure(SCRIPT[r].value[CSR_BITS-1:0]);
         end else begin
            send_item(SCRIPT[r].lane, SCRIPT[r].value, SCRIPT[r].lane_end,
                      SCRIPT[r].typed, SCRIPT[r].want);
         end
      end

      // Random merges: mostly well-formed lane refills, with some stray transactions.
      plan_merge();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 200 && i < 300);
         open_lanes.delete();
         for (int k = 0; k < live_lanes(); k++) begin
            if (!head_full[k] && !lane_done[k]) open_lanes.push_back(k);
         end
         if (open_lanes.size() == 0 || $urandom_range(99) < 12) begin
            lane = $urandom_range(LANES - 1);
            value = $urandom;
            lane_end = $urandom_range(1);
         end else begin
            l = open_lanes[$urandom_range(open_lanes.size() - 1)];
            lane = LANE_BITS'(l);
            if (lane_budget[l] == 0) begin
               value = $urandom;
               lane_end = 1'b1;
            end else begin
               // Next element of the lane: a tie, a small or large step, or the maximum.
               pick = $urandom_range(9);
               if (pick < 2) next_val = lane_last[l];
               else if (pick < 8) next_val = longint'(lane_last[l]) + $urandom_range(1, 100);
               else if (pick == 8) next_val = longint'(lane_last[l]) + $urandom;
               else next_val = longint'(VAL_MAX);
               if (next_val > longint'(VAL_MAX)) next_val = longint'(VAL_MAX);
               value = next_val[VALUE_BITS-1:0];
               lane_last[l] = value;
               lane_budget[l]--;
               lane_end = 1'b0;
            end
         end
         send_item(lane, value, lane_end, 1'b0, NO_CHECK);
         // A finished merge leaves every lane clear, so the lane count may change here.
         if (restarted) begin
            if ($urandom_range(2) == 0) begin
               pick = $urandom_range(3);
               reconfigure(pick == 0 ? 4'd1 : pick == 1 ? 4'd8
                                            : CSR_BITS'($urandom_range(15)));
            end
            plan_merge();
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("** k_way_merge_selector: PASSED **");
      end else begin
         $display("** k_way_merge_selector: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/kwm_pkg.sv
sv/kwm_min_tree.sv
sv/kwm_lanes.sv
sv/k_way_merge_selector.sv
tb/sv/tb_k_way_merge_selector.sv
